@@ src/prr_pkg.sv @@
// Shared types, constants and lookup functions for the permutation rank/unrank block.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

   localparam int MAX_SYMBOLS = 10;
   localparam int DIGIT_W     = 4;
   localparam int PERM_W      = 40;
   localparam int INDEX_W     = 22;
   localparam int LEN_W       = 4;
   localparam int COUNT_W     = 4;
   localparam int LEN_RESET   = 10;

   // rank path: two lane stages, then a four level adder tree
   localparam int TREE_LEVELS = 4;
   localparam int RANK_LAT    = 2 + TREE_LEVELS;
   // unrank path: range check plus one stage per position
   localparam int RANK_DELAY  = MAX_SYMBOLS + 1 - RANK_LAT;

   typedef logic [LEN_W-1:0]       len_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [DIGIT_W-1:0]     digit_type;
   typedef logic [INDEX_W-1:0]     index_type;
   typedef logic [PERM_W-1:0]      perm_type;
   typedef logic [MAX_SYMBOLS-1:0] sym_type;

   typedef enum logic {
      OP_RANK   = 1'b0,
      OP_UNRANK = 1'b1
   } op_type;

   typedef struct packed {
      logic      operation;
      perm_type  perm_packed;
      index_type index_in;
   } req_type;

   typedef struct packed {
      index_type index_out;
      perm_type  perm_out;
      logic      error;
   } rsp_type;

   // one rank lane's weighted count, also used for tree nodes
   typedef struct packed {
      logic      bad;
      index_type product;
   } lane_out_type;

   // item state carried down the unrank chain
   typedef struct packed {
      logic      valid;
      logic      operation;
      logic      error;
      index_type remainder;
      sym_type   used;
      perm_type  perm;
   } dig_stage_type;

   function automatic index_type factorial(input len_type k);
      index_type f;
      unique case (k)
         len_type'(0):  f = index_type'(1);
         len_type'(1):  f = index_type'(1);
         len_type'(2):  f = index_type'(2);
         len_type'(3):  f = index_type'(6);
         len_type'(4):  f = index_type'(24);
         len_type'(5):  f = index_type'(120);
         len_type'(6):  f = index_type'(720);
         len_type'(7):  f = index_type'(5040);
         len_type'(8):  f = index_type'(40320);
         len_type'(9):  f = index_type'(362880);
         len_type'(10): f = index_type'(3628800);
         default:       f = '0;
      endcase
      return f;
   endfunction

   // zero reads as one symbol, large values clamp to the maximum
   function automatic len_type eff_length(input len_type raw);
      len_type n;
      n = raw;
      if (raw == '0) begin
         n = len_type'(1);
      end else if (raw > len_type'(MAX_SYMBOLS)) begin
         n = len_type'(MAX_SYMBOLS);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ src/prr_rank_lane.sv @@
// One rank lane: counts smaller later digits for its position and weights the count.
`timescale 1ns / 1ps
`default_nettype none

module prr_rank_lane (
   input  wire                    clock,
   input  wire prr_pkg::digit_type digit,
   input  wire prr_pkg::perm_type  perm_packed,
   input  wire prr_pkg::sym_type   later_mask,
   input  wire                    lane_on,
   input  wire prr_pkg::len_type   weight_sel,
   input  wire prr_pkg::len_type   len,
   output prr_pkg::lane_out_type   lane_out
);

   prr_pkg::sym_type      smaller;
   prr_pkg::count_type    cnt_in;
   prr_pkg::count_type    cnt_ff;
   logic                  bad_in;
   logic                  bad_ff;
   prr_pkg::index_type    weight_in;
   prr_pkg::index_type    weight_ff;
   prr_pkg::lane_out_type lane_ff;

   always_comb begin
      for (int j = 0; j < prr_pkg::MAX_SYMBOLS; j++) begin
         smaller[j] = later_mask[j] &&
                      (perm_packed[j*prr_pkg::DIGIT_W +: prr_pkg::DIGIT_W] < digit);
      end
      cnt_in    = prr_pkg::count_type'($countones(smaller));
      bad_in    = lane_on && (prr_pkg::len_type'(digit) >= len);
      weight_in = prr_pkg::factorial(weight_sel);
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      bad_ff    <= bad_in;
      weight_ff <= weight_in;
      lane_ff.bad     <= bad_ff;
      lane_ff.product <= prr_pkg::index_type'(prr_pkg::index_type'(cnt_ff) * weight_ff);
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

@@ src/prr_merge.sv @@
// Registered adder tree that sums the lane products and ORs the digit errors.
`timescale 1ns / 1ps
`default_nettype none

module prr_merge (
   input  wire prr_pkg::lane_out_type lanes [prr_pkg::MAX_SYMBOLS],
   input  wire                       clock,
   output prr_pkg::lane_out_type     rank_out
);

   localparam int L1_N = (prr_pkg::MAX_SYMBOLS + 1) / 2;
   localparam int L2_N = (L1_N + 1) / 2;
   localparam int L3_N = (L2_N + 1) / 2;
   localparam int L4_N = (L3_N + 1) / 2;

   prr_pkg::lane_out_type lvl1_ff [L1_N];
   prr_pkg::lane_out_type lvl2_ff [L2_N];
   prr_pkg::lane_out_type lvl3_ff [L3_N];
   prr_pkg::lane_out_type lvl4_ff [L4_N];

   always_ff @(posedge clock) begin
      for (int j = 0; j < L1_N; j++) begin
         if (2*j + 1 < prr_pkg::MAX_SYMBOLS) begin
            lvl1_ff[j].product <= lanes[2*j].product + lanes[2*j+1].product;
            lvl1_ff[j].bad     <= lanes[2*j].bad | lanes[2*j+1].bad;
         end else begin
            lvl1_ff[j] <= lanes[2*j];
         end
      end
      for (int j = 0; j < L2_N; j++) begin
         if (2*j + 1 < L1_N) begin
            lvl2_ff[j].product <= lvl1_ff[2*j].product + lvl1_ff[2*j+1].product;
            lvl2_ff[j].bad     <= lvl1_ff[2*j].bad | lvl1_ff[2*j+1].bad;
         end else begin
            lvl2_ff[j] <= lvl1_ff[2*j];
         end
      end
      for (int j = 0; j < L3_N; j++) begin
         if (2*j + 1 < L2_N) begin
            lvl3_ff[j].product <= lvl2_ff[2*j].product + lvl2_ff[2*j+1].product;
            lvl3_ff[j].bad     <= lvl2_ff[2*j].bad | lvl2_ff[2*j+1].bad;
         end else begin
            lvl3_ff[j] <= lvl2_ff[2*j];
         end
      end
      for (int j = 0; j < L4_N; j++) begin
         if (2*j + 1 < L3_N) begin
            lvl4_ff[j].product <= lvl3_ff[2*j].product + lvl3_ff[2*j+1].product;
            lvl4_ff[j].bad     <= lvl3_ff[2*j].bad | lvl3_ff[2*j+1].bad;
         end else begin
            lvl4_ff[j] <= lvl3_ff[2*j];
         end
      end
   end

   assign rank_out = lvl4_ff[0];

endmodule

`default_nettype wire

@@ src/prr_digit_stage.sv @@
// One unrank stage: extracts a factorial-base digit and picks the matching unused value.
`timescale 1ns / 1ps
`default_nettype none

module prr_digit_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire prr_pkg::len_type       stage_idx,
   input  wire                        stage_on,
   input  wire prr_pkg::index_type     mult [prr_pkg::MAX_SYMBOLS],
   input  wire prr_pkg::dig_stage_type up_stage,
   output prr_pkg::dig_stage_type      stage_out
);

   prr_pkg::count_type     q;
   prr_pkg::index_type     rem_next;
   prr_pkg::sym_type       free;
   prr_pkg::sym_type       below;
   prr_pkg::sym_type       hit;
   prr_pkg::digit_type     pick;
   prr_pkg::dig_stage_type stage_in;
   prr_pkg::dig_stage_type stage_ff;

   always_comb begin
      // multiples rise with k, so the last one not above the remainder is the digit
      q = '0;
      for (int k = 1; k < prr_pkg::MAX_SYMBOLS; k++) begin
         if (up_stage.remainder >= mult[k]) begin
            q = prr_pkg::count_type'(k);
         end
      end
      rem_next = up_stage.remainder - mult[q];

      // q-th free value: free, with exactly q free values below it
      free  = ~up_stage.used;
      below = '0;
      for (int v = 0; v < prr_pkg::MAX_SYMBOLS; v++) begin
         below  = free & ~(prr_pkg::sym_type'({prr_pkg::MAX_SYMBOLS{1'b1}} << v));
         hit[v] = free[v] && (prr_pkg::count_type'($countones(below)) == q);
      end
      pick = '0;
      for (int v = 0; v < prr_pkg::MAX_SYMBOLS; v++) begin
         if (hit[v]) begin
            pick = pick | prr_pkg::digit_type'(v);
         end
      end

      stage_in = up_stage;
      if (stage_on && (up_stage.operation == prr_pkg::OP_UNRANK) && !up_stage.error) begin
         stage_in.remainder  = rem_next;
         stage_in.used[pick] = 1'b1;
         stage_in.perm[stage_idx*prr_pkg::DIGIT_W +: prr_pkg::DIGIT_W] = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

@@ src/permutation_rank_unrank.sv @@
// Top level of the permutation rank/unrank engine (Lehmer code, lexicographic order).
//  - An item is taken at a rising edge with start high and busy low. busy is
//    always low: the engine is fully pipelined and takes one item per clock.
//  - operation OP_RANK ranks req_item.perm_packed (four bits per position,
//    position 0 in the low nibble); OP_UNRANK turns req_item.index_in into a
//    permutation. The unused result field reads zero, and on error both do.
//  - The result of an item passes the entry register, the range check and the
//    ten digit stages, then shows on rsp_item with rsp_strobe high. The strobe
//    lasts one cycle; the receiver cannot hold it off and needs no handshake back.
//  - Ranking runs in ten lanes (one per position) that count smaller later
//    digits and weight them by a factorial, then a four level adder tree; its
//    result is delayed to line up with unranking.
//  - Unranking checks the index against n!, then walks one stage per position:
//    each stage compares against a row of precomputed multiples of the stage
//    factorial and picks the q-th unused value. The ten stages set the latency.
//  - csr_write_data sets the length n (0 reads as 1, above 10 clamps to 10).
//    Write it only while no item is in flight; the multiples table is rebuilt
//    from the length register before any new item reaches the first digit stage.
//  - Reset empties the pipeline and sets the length to 10.
`timescale 1ns / 1ps
`default_nettype none

module permutation_rank_unrank (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire prr_pkg::req_type  req_item,
   output logic                  rsp_strobe,
   output prr_pkg::rsp_type      rsp_item,
   input  wire                   csr_write_enable,
   input  wire prr_pkg::len_type  csr_write_data
);

   // configuration
   prr_pkg::len_type      len_ff;
   prr_pkg::len_type      len_in;

   // item entry register
   logic                  in_valid_ff;
   prr_pkg::req_type      in_req_ff;

   // per stage multiples k * (n-1-i)!, rebuilt from the length register
   prr_pkg::index_type    mult_ff [prr_pkg::MAX_SYMBOLS][prr_pkg::MAX_SYMBOLS];
   prr_pkg::sym_type      stage_on_ff;

   // rank lanes
   prr_pkg::sym_type      later_mask [prr_pkg::MAX_SYMBOLS];
   prr_pkg::sym_type      lane_on;
   prr_pkg::len_type      weight_sel [prr_pkg::MAX_SYMBOLS];
   prr_pkg::lane_out_type lane_out   [prr_pkg::MAX_SYMBOLS];
   prr_pkg::lane_out_type rank_q;
   prr_pkg::lane_out_type rank_dly_ff [prr_pkg::RANK_DELAY];
   prr_pkg::lane_out_type rank_tap;

   // unrank chain
   prr_pkg::dig_stage_type dig0_in;
   prr_pkg::dig_stage_type dig0_ff;
   prr_pkg::dig_stage_type dig_chain [prr_pkg::MAX_SYMBOLS+1];
   prr_pkg::dig_stage_type dig_last;

   assign busy = 1'b0;

   // length register
   always_comb begin
      len_in = len_ff;
      if (csr_write_enable) begin
         len_in = prr_pkg::eff_length(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= prr_pkg::eff_length(prr_pkg::len_type'(prr_pkg::LEN_RESET));
      end else begin
         len_ff <= len_in;
      end
   end

   // entry register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         in_req_ff <= req_item;
      end
   end

   // multiples table; inactive stages get zeros and are bypassed
   always_ff @(posedge clock) begin
      for (int i = 0; i < prr_pkg::MAX_SYMBOLS; i++) begin
         stage_on_ff[i] <= prr_pkg::len_type'(i) < len_ff;
         for (int k = 0; k < prr_pkg::MAX_SYMBOLS; k++) begin
            if (prr_pkg::len_type'(i) < len_ff) begin
               mult_ff[i][k] <= prr_pkg::index_type'(
                  prr_pkg::index_type'(k) *
                  prr_pkg::factorial(len_ff - prr_pkg::len_type'(i) - prr_pkg::len_type'(1)));
            end else begin
               mult_ff[i][k] <= '0;
            end
         end
      end
   end

   // rank lanes: lane g sees later positions g+1..n-1 only
   always_comb begin
      for (int g = 0; g < prr_pkg::MAX_SYMBOLS; g++) begin
         lane_on[g] = prr_pkg::len_type'(g) < len_ff;
         weight_sel[g] = '0;
         if (lane_on[g]) begin
            weight_sel[g] = len_ff - prr_pkg::len_type'(g) - prr_pkg::len_type'(1);
         end
         for (int j = 0; j < prr_pkg::MAX_SYMBOLS; j++) begin
            later_mask[g][j] = (j > g) && (prr_pkg::len_type'(j) < len_ff);
         end
      end
   end

   for (genvar g = 0; g < prr_pkg::MAX_SYMBOLS; g++) begin : g_lane
      prr_rank_lane u_lane (
         .clock       (clock),
         .digit       (in_req_ff.perm_packed[g*prr_pkg::DIGIT_W +: prr_pkg::DIGIT_W]),
         .perm_packed (in_req_ff.perm_packed),
         .later_mask  (later_mask[g]),
         .lane_on     (lane_on[g]),
         .weight_sel  (weight_sel[g]),
         .len         (len_ff),
         .lane_out    (lane_out[g])
      );
   end

   prr_merge u_merge (
      .lanes    (lane_out),
      .clock    (clock),
      .rank_out (rank_q)
   );

   // align rank with the unrank chain
   always_ff @(posedge clock) begin
      rank_dly_ff[0] <= rank_q;
      for (int k = 1; k < prr_pkg::RANK_DELAY; k++) begin
         rank_dly_ff[k] <= rank_dly_ff[k-1];
      end
   end

   assign rank_tap = rank_dly_ff[prr_pkg::RANK_DELAY-1];

   // unrank range check: index must be below n!
   always_comb begin
      dig0_in.valid     = in_valid_ff;
      dig0_in.operation = in_req_ff.operation;
      dig0_in.error     = (in_req_ff.operation == prr_pkg::OP_UNRANK) &&
                          (in_req_ff.index_in >= prr_pkg::factorial(len_ff));
      dig0_in.remainder = in_req_ff.index_in;
      dig0_in.used      = '0;
      dig0_in.perm      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig0_ff <= '0;
      end else begin
         dig0_ff <= dig0_in;
      end
   end

   assign dig_chain[0] = dig0_ff;

   for (genvar s = 0; s < prr_pkg::MAX_SYMBOLS; s++) begin : g_digit
      prr_digit_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (prr_pkg::len_type'(s)),
         .stage_on  (stage_on_ff[s]),
         .mult      (mult_ff[s]),
         .up_stage  (dig_chain[s]),
         .stage_out (dig_chain[s+1])
      );
   end

   assign dig_last = dig_chain[prr_pkg::MAX_SYMBOLS];

   // result select; both sides come straight from registers
   always_comb begin
      rsp_strobe = dig_last.valid;
      rsp_item   = '0;
      unique case (dig_last.operation)
         prr_pkg::OP_RANK: begin
            rsp_item.error = rank_tap.bad;
            if (!rank_tap.bad) begin
               rsp_item.index_out = rank_tap.product;
            end
         end
         prr_pkg::OP_UNRANK: begin
            rsp_item.error = dig_last.error;
            if (!dig_last.error) begin
               rsp_item.perm_out = dig_last.perm;
            end
         end
         default: begin
            rsp_item = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ tb/permutation_rank_unrank_test.sv @@
// Self-checking testbench: directed table and random items, scored against a Lehmer code predictor.
`timescale 1ns / 1ps

module permutation_rank_unrank_test;
   import prr_pkg::*;

   // Cycles with no item taken and no result seen before the run is abandoned.
   // The slowest correct stretch is a drain plus the longest random gap, so
   // this leaves a wide margin.
   localparam int IDLE_LIMIT   = 2000;
   // Extra cycles to wait at the end, after the drain, so a stray extra
   // result would still be caught.
   localparam int TAIL_CYCLES  = 16;
   localparam int RANDOM_ITEMS = 930;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   req_type  req_item;
   logic     rsp_strobe;
   rsp_type  rsp_item;
   logic     csr_write_enable;
   len_type  csr_write_data;

   permutation_rank_unrank dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // One row of the directed table. Rows with known set carry a result that
   // is typed in by hand; the rest are scored by the predictor.
   typedef struct {
      len_type length;
      req_type stim;
      bit      known;
      rsp_type want;
   } vector_row;

   vector_row directed_rows[$];
   rsp_type   pending_conversions[$];   // one per item taken, oldest first
   len_type   length_reg;               // our copy of the length register
   int        mismatches;
   int        idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // n! for the small n this block handles
   function automatic longint unsigned orderings(input int k);
      longint unsigned f;
      f = 1;
      for (int i = 2; i <= k; i++) f = f * i;
      return f;
   endfunction

   // Length register as the block sees it: 0 means one symbol, big values clamp.
   function automatic int symbol_count(input len_type raw);
      int n;
      n = int'(raw);
      if (n == 0) n = 1;
      if (n > MAX_SYMBOLS) n = MAX_SYMBOLS;
      return n;
   endfunction

   // Expected result of one item under a given length register.
   function automatic rsp_type convert_item(input req_type item, input len_type raw);
      rsp_type         res;
      int              n;
      bit              bad;
      int              digit [MAX_SYMBOLS];
      int              smaller;
      longint unsigned rank;
      longint unsigned rest;
      longint unsigned f;
      longint unsigned q;
      int              skipped;
      int              pick;
      bit [MAX_SYMBOLS-1:0] taken;

      res = '0;
      n = symbol_count(raw);
      if (item.operation == OP_RANK) begin
         bad = 1'b0;
         for (int i = 0; i < n; i++) begin
            digit[i] = int'(item.perm_packed[DIGIT_W*i +: DIGIT_W]);
            if (digit[i] >= n) bad = 1'b1;
         end
         if (bad) begin
            res.error = 1'b1;
         end else begin
            // count smaller later digits, weight by the factorial of what is left;
            // repeated digits go through the same sum and never flag
            rank = 0;
            for (int i = 0; i < n; i++) begin
               smaller = 0;
               for (int j = i + 1; j < n; j++) begin
                  if (digit[j] < digit[i]) smaller++;
               end
               rank = rank + smaller * orderings(n - 1 - i);
            end
            res.index_out = index_type'(rank);
         end
      end else begin
         rest = longint'(item.index_in);
         if (rest >= orderings(n)) begin
            res.error = 1'b1;
         end else begin
            taken = '0;
            for (int i = 0; i < n; i++) begin
               f = orderings(n - 1 - i);
               q = rest / f;
               rest = rest % f;
               // q-th value not yet placed, counting upward
               skipped = 0;
               pick = 0;
               for (int v = 0; v < n; v++) begin
                  if (!taken[v]) begin
                     if (skipped == int'(q)) begin
                        pick = v;
                        break;
                     end
                     skipped++;
                  end
               end
               taken[pick] = 1'b1;
               res.perm_out[DIGIT_W*i +: DIGIT_W] = digit_type'(pick);
            end
         end
      end
      return res;
   endfunction

   // Random item for n symbols. Mostly well-formed permutations and in-range
   // indexes, since those exercise every lane and every digit stage; the rest
   // are repeated digits, range edges and raw noise.
   function automatic req_type random_item(input int n);
      req_type         item;
      int              vals [MAX_SYMBOLS];
      int              j;
      int              tmp;
      int              pick;
      longint unsigned f;

      item.perm_packed = perm_type'({$urandom, $urandom});
      item.index_in    = index_type'($urandom);
      item.operation   = $urandom_range(0, 1) ? OP_UNRANK : OP_RANK;
      pick = $urandom_range(0, 99);
      f = orderings(n);
      if (item.operation == OP_RANK) begin
         if (pick < 75) begin
            for (int i = 0; i < n; i++) vals[i] = i;
            for (int i = n - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = vals[i];
               vals[i] = vals[j];
               vals[j] = tmp;
            end
            for (int i = 0; i < n; i++)
               item.perm_packed[DIGIT_W*i +: DIGIT_W] = digit_type'(vals[i]);
         end else if (pick < 90) begin
            // in range but possibly repeated
            for (int i = 0; i < n; i++)
               item.perm_packed[DIGIT_W*i +: DIGIT_W] = digit_type'($urandom_range(0, n - 1));
         end
      end else begin
         if (pick < 75) begin
            item.index_in = index_type'($urandom_range(0, int'(f) - 1));
         end else if (pick < 88) begin
            case ($urandom_range(0, 2))
               0: item.index_in = '0;
               1: item.index_in = index_type'(f - 1);
               default: item.index_in = index_type'(f);
            endcase
         end
      end
      return item;
   endfunction

   function automatic void add_row(input len_type length, input op_type op,
                                   input perm_type perm, input index_type idx,
                                   input bit known, input index_type want_index,
                                   input perm_type want_perm, input bit want_error);
      vector_row row;
      row.length                = length;
      row.stim.operation        = op;
      row.stim.perm_packed      = perm;
      row.stim.index_in         = idx;
      row.known                 = known;
      row.want.index_out        = want_index;
      row.want.perm_out         = want_perm;
      row.want.error            = want_error;
      directed_rows.push_back(row);
   endfunction

   // Called at a falling edge. Holds start until the item is taken, then
   // returns at the next falling edge with start still high, so back-to-back
   // items never see start dropped and raised in one step.
   task automatic issue_item(input req_type item, input rsp_type want, input int gap);
      bit taken;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         if (taken) pending_conversions.push_back(want);
         @(negedge clock);
      end
   endtask

   // Stop sending and wait for every outstanding result; ends at a falling edge.
   task automatic drain_results;
      start <= 1'b0;
      while (pending_conversions.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // The length register may only change with the pipeline empty.
   task automatic write_length(input len_type value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      length_reg = value;
   endtask

   // Result checker: every strobe must match the oldest outstanding item.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_conversions.size() == 0) begin
            $error("result with no item outstanding: index_out %0d perm_out %h error %0b",
                   rsp_item.index_out, rsp_item.perm_out, rsp_item.error);
            mismatches++;
         end else begin
            want = pending_conversions.pop_front();
            if (rsp_item.index_out !== want.index_out) begin
               $error("index_out: expected %0d, got %0d", want.index_out, rsp_item.index_out);
               mismatches++;
            end
            if (rsp_item.perm_out !== want.perm_out) begin
               $error("perm_out: expected %h, got %h", want.perm_out, rsp_item.perm_out);
               mismatches++;
            end
            if (rsp_item.error !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_item.error);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any taken item or result resets the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      vector_row row;
      req_type   item;
      int        sent;
      int        phase;
      int        phase_items;
      bit        quiet;
      len_type   extremes [4];

      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      length_reg       = len_type'(LEN_RESET);
      mismatches       = 0;
      idle_cycles      = 0;

      // --- directed table --------------------------------------------------
      // n = 10 straight out of reset, no write yet: identity and reversal are
      // the first and last ranks; n! and the all-ones index overflow.
      add_row(4'd10, OP_RANK,   40'h9876543210, 22'h3FFFFF, 1, '0, '0, 0);
      add_row(4'd10, OP_RANK,   40'h0123456789, '0, 1, 22'd3628799, '0, 0);
      add_row(4'd10, OP_UNRANK, 40'hFFFFFFFFFF, '0, 1, '0, 40'h9876543210, 0);
      add_row(4'd10, OP_UNRANK, '0, 22'd3628799, 1, '0, 40'h0123456789, 0);
      add_row(4'd10, OP_UNRANK, '0, 22'd3628800, 1, '0, '0, 1);
      add_row(4'd10, OP_UNRANK, '0, 22'h3FFFFF, 1, '0, '0, 1);
      // a digit of 15 in the top position, then all digits bad
      add_row(4'd10, OP_RANK,   40'hF876543210, '0, 1, '0, '0, 1);
      add_row(4'd10, OP_RANK,   40'hFFFFFFFFFF, '0, 1, '0, '0, 1);
      // repeated digits are not flagged
      add_row(4'd10, OP_RANK,   40'h0000000000, '0, 1, '0, '0, 0);
      add_row(4'd10, OP_RANK,   40'h0101010101, '0, 0, '0, '0, 0);
      add_row(4'd10, OP_RANK,   40'h2705164938, '0, 0, '0, '0, 0);
      add_row(4'd10, OP_UNRANK, '0, 22'd1234567, 0, '0, '0, 0);
      // length 0 reads as one symbol: only position 0 counts
      add_row(4'd0,  OP_RANK,   40'hFFFFFFFFF0, '0, 1, '0, '0, 0);
      add_row(4'd0,  OP_RANK,   40'h0000000001, '0, 1, '0, '0, 1);
      add_row(4'd0,  OP_UNRANK, '0, '0, 1, '0, '0, 0);
      add_row(4'd0,  OP_UNRANK, '0, 22'd1, 1, '0, '0, 1);
      // length 15 clamps to ten symbols
      add_row(4'd15, OP_UNRANK, '0, 22'd3628799, 1, '0, 40'h0123456789, 0);
      add_row(4'd15, OP_RANK,   40'h0123456789, '0, 1, 22'd3628799, '0, 0);
      add_row(4'd1,  OP_UNRANK, '0, 22'h3FFFFF, 1, '0, '0, 1);
      // two symbols: upper nibbles are don't-care
      add_row(4'd2,  OP_UNRANK, '0, 22'd1, 1, '0, 40'h01, 0);
      add_row(4'd2,  OP_RANK,   40'hABCDEF0001, '0, 1, 22'd1, '0, 0);
      add_row(4'd2,  OP_RANK,   40'h0000000002, '0, 1, '0, '0, 1);
      add_row(4'd4,  OP_RANK,   40'h0000000213, '0, 0, '0, '0, 0);
      add_row(4'd4,  OP_UNRANK, '0, 22'd23, 0, '0, '0, 0);
      add_row(4'd4,  OP_UNRANK, '0, 22'd24, 1, '0, '0, 1);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.length != length_reg) write_length(row.length);
         issue_item(row.stim, row.known ? row.want : convert_item(row.stim, length_reg),
                    $urandom_range(0, 9));
      end

      // --- random phases -------------------------------------------------------
      // Each phase drains the pipeline (the sender waits out every result), sets
      // a new length, then streams items. The first phases hit the extremes.
      extremes[0] = 4'd1;
      extremes[1] = 4'd10;
      extremes[2] = 4'd15;
      extremes[3] = 4'd0;
      sent  = 0;
      phase = 0;
      quiet = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         write_length(phase < 4 ? extremes[phase] : len_type'($urandom_range(0, 15)));
         phase_items = $urandom_range(60, 110);
         for (int k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
            // every 16 items decide whether the next stretch runs gap-free
            if (k % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
            item = random_item(symbol_count(length_reg));
            issue_item(item, convert_item(item, length_reg), quiet ? 0 : $urandom_range(0, 9));
            sent++;
         end
         phase++;
      end

      // --- wind down -----------------------------------------------------------
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_conversions.size() != 0) begin
         $error("%0d items never produced a result", pending_conversions.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/prr_pkg.sv
src/prr_rank_lane.sv
src/prr_merge.sv
src/prr_digit_stage.sv
src/permutation_rank_unrank.sv
tb/permutation_rank_unrank_test.sv
